FILE: hw/rtl/msk_pkg.sv
package msk_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int WORD_WIDTH  = VALUE_WIDTH + 2;
  localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
  localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);

  localparam int ACT_WIDTH   = 2;
  localparam int STAT_WIDTH  = 2;

  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * VALUE_WIDTH + 1 + CNT_WIDTH + STAT_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [WORD_WIDTH-1:0]  word_t;
  typedef logic [CNT_WIDTH-1:0]          count_t;

  typedef enum logic [ACT_WIDTH-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [STAT_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_POP_RD
  } state_e;

  typedef struct packed {
    status_e status;
    count_t  count;
    logic    is_empty;
    value_t  min_value;
    value_t  top_value;
  } msk_result_t;

  function automatic word_t sext_word(value_t v);
    return {{(WORD_WIDTH - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
  endfunction

  function automatic msk_result_t make_result(count_t fill, value_t mn, word_t w,
                                              status_e st);
    msk_result_t r;
    r.status    = st;
    r.count     = fill;
    r.is_empty  = (fill == '0);
    r.min_value = '0;
    r.top_value = '0;
    if (fill != '0) begin
      r.min_value = mn;
      r.top_value = (w < sext_word(mn)) ? mn : w[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/min_stack_encoded.sv
// Channel   Dir  Handshake                tuser         tdata
// s_axis    in   s_axis_tvalid/tready     action[1:0]   value[31:0]
// m_axis    out  m_axis_tvalid/tready     -             top,min,is_empty,count,status
//
// Push, query, dropped push and ignored pop: result valid in the cycle after the transfer.
// Pop of a held word: the S_POP_RD state reads the new top word from the synchronous stack
// memory and holds s_axis_tready_o low, then the result is registered.
// Reset clears the fill level, the minimum and all handshake state.
// A new item is taken in S_IDLE once the output register is empty or being drained.
module min_stack_encoded
  import msk_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [1:0] action
  input  logic [ACT_WIDTH-1:0]   s_axis_tuser_i,
  // [31:0] value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [31:0] top_value, [63:32] min_value, [64] is_empty, [71:65] count,
  // [73:72] status, upper bits zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic        out_valid_q, out_valid_d;
  msk_result_t out_res_q;
  logic        out_free;
  logic        res_valid;
  msk_result_t res;

  assign out_free = !out_valid_q || m_axis_tready_i;

  msk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .action_i   (action_e'(s_axis_tuser_i)),
    .value_i    (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_res_q};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_q || m_axis_tready_i)
    else $error("result overwrites pending transfer");

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> out_free)
    else $error("input ready without output room");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.is_empty |->
      out_res_q.top_value == '0 && out_res_q.min_value == '0 && out_res_q.count == '0)
    else $error("empty result not zero");

endmodule

FILE: hw/rtl/msk_ram.sv
module msk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/msk_ctrl.sv
module msk_ctrl
  import msk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  action_e     action_i,
  input  value_t      value_i,
  input  logic        out_free_i,
  output logic        res_valid_o,
  output msk_result_t res_o
);

  state_e state_q, state_d;
  count_t fill_q, fill_d;
  value_t min_q, min_d;
  word_t  top_q, top_d;

  logic                  in_fire;
  logic                  mem_we;
  logic [ADDR_WIDTH-1:0] mem_waddr;
  word_t                 mem_wdata;
  logic                  mem_re;
  logic [ADDR_WIDTH-1:0] mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;
  count_t                fill_m2;
  word_t                 x_w;
  word_t                 enc_w;
  word_t                 dec_w;

  msk_ram #(
    .Width(WORD_WIDTH),
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_fire = in_valid_i && in_ready_o;
  assign x_w     = sext_word(value_i);
  assign enc_w   = (x_w <<< 1) - sext_word(min_q);
  assign dec_w   = (sext_word(min_q) <<< 1) - top_q;
  assign fill_m2 = fill_q - count_t'(2);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && action_i == ACT_POP && fill_q != '0) begin
          state_d = S_POP_RD;
        end
      end
      S_POP_RD: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE:   in_ready_o = out_free_i;
      S_POP_RD: in_ready_o = 1'b0;
      default:  in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    fill_d      = fill_q;
    min_d       = min_q;
    top_d       = top_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_q[ADDR_WIDTH-1:0];
    mem_wdata   = x_w;
    mem_re      = 1'b0;
    mem_raddr   = fill_m2[ADDR_WIDTH-1:0];
    res_valid_o = 1'b0;
    res_o       = make_result(fill_q, min_q, top_q, ST_OK);
    if (state_q == S_POP_RD) begin
      top_d       = word_t'(mem_rdata);
      res_valid_o = 1'b1;
      res_o       = make_result(fill_q, min_q, word_t'(mem_rdata), ST_OK);
    end else if (in_fire) begin
      case (action_i)
        ACT_PUSH: begin
          if (fill_q == count_t'(STACK_DEPTH)) begin
            res_valid_o = 1'b1;
            res_o       = make_result(fill_q, min_q, top_q, ST_FULL);
          end else begin
            if (fill_q == '0 || x_w >= sext_word(min_q)) begin
              mem_wdata = x_w;
            end else begin
              mem_wdata = enc_w;
            end
            if (fill_q == '0 || x_w < sext_word(min_q)) begin
              min_d = value_i;
            end
            mem_we      = 1'b1;
            top_d       = mem_wdata;
            fill_d      = fill_q + count_t'(1);
            res_valid_o = 1'b1;
            res_o       = make_result(fill_d, min_d, top_d, ST_OK);
          end
        end
        ACT_POP: begin
          if (fill_q == '0) begin
            res_valid_o = 1'b1;
            res_o       = make_result(fill_q, min_q, top_q, ST_EMPTY);
          end else begin
            if (top_q < sext_word(min_q)) begin
              min_d = dec_w[VALUE_WIDTH-1:0];
            end
            fill_d = fill_q - count_t'(1);
            mem_re = 1'b1;
          end
        end
        default: begin
          res_valid_o = 1'b1;
          res_o       = make_result(fill_q, min_q, top_q, ST_OK);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      min_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      min_q   <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= count_t'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  a_pop_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |=> state_q == S_IDLE)
    else $error("pop read stage held");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |-> res_valid_o && !in_ready_o)
    else $error("pop read without result");

  a_write_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> in_fire && action_i == ACT_PUSH && fill_q < count_t'(STACK_DEPTH))
    else $error("memory write outside push");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |-> fill_q == $past(fill_q) - count_t'(1))
    else $error("pop fill mismatch");

endmodule
